FILE: sv/touch_sample_average_and_grid_map_core_assert.svh
// assertion macros used by the checker file
`ifndef TOUCH_SAMPLE_AVERAGE_AND_GRID_MAP_CORE_ASSERT_SVH
`define TOUCH_SAMPLE_AVERAGE_AND_GRID_MAP_CORE_ASSERT_SVH

// same-cycle implication
`define TSAGM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSAGM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tsagm_pkg.sv
package tsagm_pkg;

    localparam int SAMPLES_DEF = 4;

    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 13;
    localparam int SUM_W      = 16;
    localparam int CMAX_W     = 8;
    localparam int MODE_W     = 3;
    localparam int DIV_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int OP_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_X_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_STOP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STOP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd6;

    localparam logic [RAW_W-1:0]  X_START_RST = 13'd0;
    localparam logic [RAW_W-1:0]  X_STOP_RST  = 13'd4095;
    localparam logic [RAW_W-1:0]  Y_START_RST = 13'd0;
    localparam logic [RAW_W-1:0]  Y_STOP_RST  = 13'd4095;
    localparam logic [CMAX_W-1:0] COLS_RST    = 8'd16;
    localparam logic [CMAX_W-1:0] ROWS_RST    = 8'd8;
    localparam logic [MODE_W-1:0] MODE_RST    = 3'd0;

    localparam int MODE_SWAP   = 0;
    localparam int MODE_FLIP_C = 1;
    localparam int MODE_FLIP_R = 2;

    localparam logic [OP_W-1:0] OP_FAC_C  = 2'd0;
    localparam logic [OP_W-1:0] OP_POS_C  = 2'd1;
    localparam logic [OP_W-1:0] OP_FAC_R  = 2'd2;
    localparam logic [OP_W-1:0] OP_POS_R  = 2'd3;

    typedef struct packed {
        logic            accept;
        logic            mean;
        logic            div_start;
        logic            wb;
        logic            emit;
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic logic [RAW_W-1:0] rebuild(input logic [BYTE_W-1:0] first,
                                                 input logic [BYTE_W-1:0] second);
        return {first, second[7:3]};
    endfunction

    function automatic logic [CMAX_W-1:0] grid_finish(input logic [DIV_W-1:0] q,
                                                      input logic [RAW_W-1:0] fac,
                                                      input logic [CMAX_W-1:0] cmax,
                                                      input logic flip);
        logic [CMAX_W-1:0] pos;
        logic [CMAX_W:0]   p1;
        p1 = {1'b0, q[CMAX_W-1:0]} + 9'd1;
        if (fac == '0) begin
            pos = cmax;
        end else if (q > 16'd255) begin
            pos = cmax;
        end else if (p1 > {1'b0, cmax}) begin
            pos = cmax;
        end else begin
            pos = p1[CMAX_W-1:0];
        end
        if (flip) begin
            pos = cmax - pos + 8'd1;
        end
        return pos;
    endfunction

endpackage

FILE: sv/tsagm_if.sv
interface tsagm_in_if
    import tsagm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] x_byte_first;
    logic [BYTE_W-1:0] x_byte_second;
    logic [BYTE_W-1:0] y_byte_first;
    logic [BYTE_W-1:0] y_byte_second;

    modport source (output valid, x_byte_first, x_byte_second, y_byte_first, y_byte_second,
                    input ready);
    modport sink (input valid, x_byte_first, x_byte_second, y_byte_first, y_byte_second,
                  output ready);
endinterface

interface tsagm_out_if
    import tsagm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [RAW_W-1:0]  raw_x_mean;
    logic [RAW_W-1:0]  raw_y_mean;
    logic [CMAX_W-1:0] column_pos;
    logic [CMAX_W-1:0] row_pos;
    logic              divide_fault;

    modport source (output valid, raw_x_mean, raw_y_mean, column_pos, row_pos, divide_fault,
                    input ready);
    modport sink (input valid, raw_x_mean, raw_y_mean, column_pos, row_pos, divide_fault,
                  output ready);
endinterface

FILE: sv/tsagm_div.sv
module tsagm_div
    import tsagm_pkg::*;
#(
    parameter int W = DIV_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic [W-1:0] o_quotient,
    output logic         o_done
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_quo, n_quo;
    logic [W-1:0]     r_den, n_den;
    logic [W:0]       trial;

    // one restoring step per cycle
    assign trial = {r_rem, r_quo[W-1]} - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_den  = i_divisor;
        end else if (r_busy) begin
            if (!trial[W]) begin
                n_rem = trial[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[W-2:0], r_quo[W-1]};
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

FILE: sv/tsagm_datapath.sv
module tsagm_datapath
    import tsagm_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [BYTE_W-1:0]     i_x_byte_first,
    input  logic [BYTE_W-1:0]     i_x_byte_second,
    input  logic [BYTE_W-1:0]     i_y_byte_first,
    input  logic [BYTE_W-1:0]     i_y_byte_second,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [RAW_W-1:0]      o_raw_x_mean,
    output logic [RAW_W-1:0]      o_raw_y_mean,
    output logic [CMAX_W-1:0]     o_column_pos,
    output logic [CMAX_W-1:0]     o_row_pos,
    output logic                  o_divide_fault
);

    localparam int CNT_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int MEAN_SH = SUM_W + $clog2(SAMPLES);
    localparam int MUL_W   = SUM_W + 2;
    localparam int PROD_W  = SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] MEAN_MUL =
        MUL_W'(((64'd1 << MEAN_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

    logic [RAW_W-1:0]  r_x_start, r_x_stop, r_y_start, r_y_stop;
    logic [CMAX_W-1:0] r_cols, r_rows;
    logic [MODE_W-1:0] r_mode;

    logic [SUM_W-1:0]  r_sum_x, r_sum_y;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAW_W-1:0]  r_mx, r_my, r_fac;
    logic [CMAX_W-1:0] r_col, r_row;
    logic              r_fault;

    logic              r_ovalid;
    logic [RAW_W-1:0]  r_o_mx, r_o_my;
    logic [CMAX_W-1:0] r_o_col, r_o_row;
    logic              r_o_fault;

    logic              swap;
    logic [RAW_W-1:0]  c_raw, c_start, c_stop, row_raw, row_start, row_stop;
    logic [RAW_W-1:0]  c_span, row_span, c_off, row_off, c_p, row_p;
    logic [DIV_W-1:0]  div_a, div_b, div_q;
    logic              div_done;
    logic              last;
    logic [PROD_W-1:0] prod_x, prod_y;
    logic [RAW_W-1:0]  mean_x, mean_y;

    assign swap      = r_mode[MODE_SWAP];
    assign c_raw     = swap ? r_my : r_mx;
    assign c_start   = swap ? r_y_start : r_x_start;
    assign c_stop    = swap ? r_y_stop : r_x_stop;
    assign row_raw   = swap ? r_mx : r_my;
    assign row_start = swap ? r_x_start : r_y_start;
    assign row_stop  = swap ? r_x_stop : r_y_stop;

    assign c_span   = (c_stop >= c_start) ? c_stop - c_start : '0;
    assign row_span = (row_stop >= row_start) ? row_stop - row_start : '0;

    always_comb begin
        c_p   = (c_raw < c_start) ? c_start : c_raw;
        c_p   = (c_p > c_stop) ? c_stop : c_p;
        row_p = (row_raw < row_start) ? row_start : row_raw;
        row_p = (row_p > row_stop) ? row_stop : row_p;
    end

    assign c_off   = c_p - c_start;
    assign row_off = row_p - row_start;

    // sum / SAMPLES by reciprocal multiply, exact for any 16-bit sum
    assign prod_x = PROD_W'(r_sum_x) * PROD_W'(MEAN_MUL);
    assign prod_y = PROD_W'(r_sum_y) * PROD_W'(MEAN_MUL);
    assign mean_x = prod_x[MEAN_SH +: RAW_W];
    assign mean_y = prod_y[MEAN_SH +: RAW_W];

    always_comb begin
        case (i_cmd.op)
            OP_FAC_C: begin
                div_a = DIV_W'(c_span);
                div_b = DIV_W'(r_cols);
            end
            OP_POS_C: begin
                div_a = DIV_W'(c_off);
                div_b = DIV_W'(r_fac);
            end
            OP_FAC_R: begin
                div_a = DIV_W'(row_span);
                div_b = DIV_W'(r_rows);
            end
            default: begin
                div_a = DIV_W'(row_off);
                div_b = DIV_W'(r_fac);
            end
        endcase
    end

    tsagm_div #(
        .W(DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_quotient (div_q),
        .o_done     (div_done)
    );

    assign last = (r_cnt == CNT_W'(SAMPLES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_start <= X_START_RST;
            r_x_stop  <= X_STOP_RST;
            r_y_start <= Y_START_RST;
            r_y_stop  <= Y_STOP_RST;
            r_cols    <= COLS_RST;
            r_rows    <= ROWS_RST;
            r_mode    <= MODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_X_START: r_x_start <= i_cfg_data[RAW_W-1:0];
                REG_X_STOP:  r_x_stop  <= i_cfg_data[RAW_W-1:0];
                REG_Y_START: r_y_start <= i_cfg_data[RAW_W-1:0];
                REG_Y_STOP:  r_y_stop  <= i_cfg_data[RAW_W-1:0];
                REG_COLS:    r_cols    <= i_cfg_data[CMAX_W-1:0];
                REG_ROWS:    r_rows    <= i_cfg_data[CMAX_W-1:0];
                REG_MODE:    r_mode    <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.accept) begin
            r_sum_x <= r_sum_x + SUM_W'(rebuild(i_x_byte_first, i_x_byte_second));
            r_sum_y <= r_sum_y + SUM_W'(rebuild(i_y_byte_first, i_y_byte_second));
            r_cnt   <= last ? '0 : r_cnt + 1'b1;
        end else if (i_cmd.mean) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean) begin
            r_mx    <= mean_x;
            r_my    <= mean_y;
            r_fault <= 1'b0;
        end else if (i_cmd.wb) begin
            case (i_cmd.op)
                OP_FAC_C: r_fac <= (r_cols != '0) ? div_q[RAW_W-1:0] : '0;
                OP_FAC_R: r_fac <= (r_rows != '0) ? div_q[RAW_W-1:0] : '0;
                OP_POS_C: begin
                    r_col <= grid_finish(div_q, r_fac, r_cols, r_mode[MODE_FLIP_C]);
                    if (r_fac == '0) r_fault <= 1'b1;
                end
                default: begin
                    r_row <= grid_finish(div_q, r_fac, r_rows, r_mode[MODE_FLIP_R]);
                    if (r_fac == '0) r_fault <= 1'b1;
                end
            endcase
        end
    end

    // output register, parts the result from the next set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_o_mx    <= r_mx;
            r_o_my    <= r_my;
            r_o_col   <= r_col;
            r_o_row   <= r_row;
            r_o_fault <= r_fault;
        end
    end

    assign o_sts.last     = last;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid    = r_ovalid;
    assign o_raw_x_mean   = r_o_mx;
    assign o_raw_y_mean   = r_o_my;
    assign o_column_pos   = r_o_col;
    assign o_row_pos      = r_o_row;
    assign o_divide_fault = r_o_fault;

endmodule

FILE: sv/tsagm_ctrl.sv
module tsagm_ctrl
    import tsagm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [OP_W-1:0] r_op, n_op;

    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        o_cmd.accept    = 1'b0;
        o_cmd.mean      = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.wb        = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.op        = r_op;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_req_valid;
                if (i_req_valid && i_sts.last) begin
                    n_op    = OP_FAC_C;
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.mean      = (r_op == OP_FAC_C);
                o_cmd.div_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.wb = 1'b1;
                    if (r_op == OP_POS_R) begin
                        n_state = S_EMIT;
                    end else begin
                        n_op    = r_op + 1'b1;
                        n_state = S_START;
                    end
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_FAC_C;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

FILE: sv/touch_sample_average_and_grid_map_core.sv
// Averages SAMPLES touch conversions per axis and maps the means onto a
// character grid. A request that does not close a set is added to the sums
// and the block stays ready. The request that closes a set loads both means
// from a reciprocal multiply and starts four 16-step divides (two scale
// factors, two positions) on one shared restoring divider; the block then
// takes no request until the divides are done and, if an earlier result
// still waits at the output, until that result is taken. Results sit in an
// output register; the next set is accumulated while one waits to be taken.
module touch_sample_average_and_grid_map_core
    import tsagm_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tsagm_in_if.sink              i_req,
    tsagm_out_if.source           o_res
);

    t_cmd cmd;
    t_sts sts;
    logic req_ready;

    tsagm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tsagm_datapath #(
        .SAMPLES(SAMPLES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_x_byte_first  (i_req.x_byte_first),
        .i_x_byte_second (i_req.x_byte_second),
        .i_y_byte_first  (i_req.y_byte_first),
        .i_y_byte_second (i_req.y_byte_second),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_raw_x_mean    (o_res.raw_x_mean),
        .o_raw_y_mean    (o_res.raw_y_mean),
        .o_column_pos    (o_res.column_pos),
        .o_row_pos       (o_res.row_pos),
        .o_divide_fault  (o_res.divide_fault)
    );

    assign i_req.ready = req_ready;

endmodule

FILE: sv/tsagm_checker.sv
`include "touch_sample_average_and_grid_map_core_assert.svh"

module tsagm_checker
    import tsagm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [RAW_W-1:0]  i_raw_x,
    input logic [RAW_W-1:0]  i_raw_y,
    input logic [CMAX_W-1:0] i_col,
    input logic [CMAX_W-1:0] i_row,
    input logic              i_fault
);

    `TSAGM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_raw_x) && $stable(i_raw_y) && $stable(i_col) && $stable(i_row) && $stable(i_fault), "stalled result changed")
    `TSAGM_ASSERT_IMP(a_pos_nonzero, i_clk, i_rst_n, i_out_valid && !i_fault, i_col != '0 && i_row != '0, "grid position zero without fault")
    `TSAGM_ASSERT_IMP(a_emit_busy, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_req_ready), "result appeared while taking requests")

endmodule

bind touch_sample_average_and_grid_map_core tsagm_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_raw_x     (o_res.raw_x_mean),
    .i_raw_y     (o_res.raw_y_mean),
    .i_col       (o_res.column_pos),
    .i_row       (o_res.row_pos),
    .i_fault     (o_res.divide_fault)
);
